// ----- rtl/arm_alu_shifter_flags_assert.svh -----
// ----------------------------------------------------------------------------
// ARM ALU assertion macros
// Shorthand for the concurrent checks of the data-processing unit.
// ----------------------------------------------------------------------------
`ifndef ARM_ALU_SHIFTER_FLAGS_ASSERT_SVH
`define ARM_ALU_SHIFTER_FLAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define ASF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define ASF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/asf_pkg.sv -----
// ----------------------------------------------------------------------------
// ARM ALU package
// Operation codes, shifter request/response and flag types.
// ----------------------------------------------------------------------------
package asf_pkg;

  localparam int unsigned FuncW = 6;
  localparam int unsigned DataW = 32;

  // Operation codes
  localparam logic [FuncW-1:0] FN_AND     = 6'd0;
  localparam logic [FuncW-1:0] FN_ANDS    = 6'd1;
  localparam logic [FuncW-1:0] FN_EOR     = 6'd2;
  localparam logic [FuncW-1:0] FN_EORS    = 6'd3;
  localparam logic [FuncW-1:0] FN_ORR     = 6'd4;
  localparam logic [FuncW-1:0] FN_ORRS    = 6'd5;
  localparam logic [FuncW-1:0] FN_BIC     = 6'd6;
  localparam logic [FuncW-1:0] FN_BICS    = 6'd7;
  localparam logic [FuncW-1:0] FN_MUL     = 6'd8;
  localparam logic [FuncW-1:0] FN_MULS    = 6'd9;
  localparam logic [FuncW-1:0] FN_MOV     = 6'd10;
  localparam logic [FuncW-1:0] FN_MOVS    = 6'd11;
  localparam logic [FuncW-1:0] FN_MVN     = 6'd12;
  localparam logic [FuncW-1:0] FN_MVNS    = 6'd13;
  localparam logic [FuncW-1:0] FN_SUB     = 6'd14;
  localparam logic [FuncW-1:0] FN_SUBS    = 6'd15;
  localparam logic [FuncW-1:0] FN_RSB     = 6'd16;
  localparam logic [FuncW-1:0] FN_RSBS    = 6'd17;
  localparam logic [FuncW-1:0] FN_SBC     = 6'd18;
  localparam logic [FuncW-1:0] FN_SBCS    = 6'd19;
  localparam logic [FuncW-1:0] FN_RSC     = 6'd20;
  localparam logic [FuncW-1:0] FN_RSCS    = 6'd21;
  localparam logic [FuncW-1:0] FN_ADD     = 6'd22;
  localparam logic [FuncW-1:0] FN_ADDS    = 6'd23;
  localparam logic [FuncW-1:0] FN_ADC     = 6'd24;
  localparam logic [FuncW-1:0] FN_ADCS    = 6'd25;
  localparam logic [FuncW-1:0] FN_TST     = 6'd26;
  localparam logic [FuncW-1:0] FN_TEQ     = 6'd27;
  localparam logic [FuncW-1:0] FN_CMP     = 6'd28;
  localparam logic [FuncW-1:0] FN_CMN     = 6'd29;
  localparam logic [FuncW-1:0] FN_NEG     = 6'd30;
  localparam logic [FuncW-1:0] FN_LSL_R   = 6'd31;
  localparam logic [FuncW-1:0] FN_LSR_R   = 6'd32;
  localparam logic [FuncW-1:0] FN_ASR_R   = 6'd33;
  localparam logic [FuncW-1:0] FN_ROR_R   = 6'd34;
  localparam logic [FuncW-1:0] FN_LSL_RC  = 6'd35;
  localparam logic [FuncW-1:0] FN_LSR_RC  = 6'd36;
  localparam logic [FuncW-1:0] FN_ASR_RC  = 6'd37;
  localparam logic [FuncW-1:0] FN_ROR_RC  = 6'd38;
  localparam logic [FuncW-1:0] FN_LSL_RS  = 6'd39;
  localparam logic [FuncW-1:0] FN_LSR_RS  = 6'd40;
  localparam logic [FuncW-1:0] FN_ASR_RS  = 6'd41;
  localparam logic [FuncW-1:0] FN_ROR_RS  = 6'd42;
  localparam logic [FuncW-1:0] FN_LSL_IS  = 6'd43;
  localparam logic [FuncW-1:0] FN_LSR_IS  = 6'd44;
  localparam logic [FuncW-1:0] FN_ASR_IS  = 6'd45;
  localparam logic [FuncW-1:0] FN_ROR_IS  = 6'd46;
  localparam logic [FuncW-1:0] FN_RRX_C   = 6'd47;
  localparam logic [FuncW-1:0] FN_RRX     = 6'd48;
  localparam logic [FuncW-1:0] FN_LOADF   = 6'd49;

  // Barrel shifter operation
  typedef enum logic [1:0] {
    SK_LSL = 2'd0,
    SK_LSR = 2'd1,
    SK_ASR = 2'd2,
    SK_ROR = 2'd3
  } shift_kind_e;

  typedef struct packed {
    shift_kind_e kind;
    logic        imm;   // count from bits 4:0 with immediate zero rules
    logic        rrx;   // rotate right one through carry
  } shift_req_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_rsp_t;

  // Condition flags, N in the top bit
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

// ----- rtl/asf_shifter.sv -----
// ----------------------------------------------------------------------------
// ARM barrel shifter
// LSL/LSR/ASR/ROR by register or immediate count, and RRX, with carry out.
// ----------------------------------------------------------------------------
module asf_shifter
  import asf_pkg::*;
(
  input  shift_req_t       req_i,
  input  logic [DataW-1:0] value_i,
  input  logic [7:0]       amount_i,
  input  logic             carry_i,
  output shift_rsp_t       rsp_o
);

  logic [7:0]          cnt;
  logic                rrx;
  logic                big;
  logic [2*DataW-1:0]  lsl_w;
  logic [2*DataW-1:0]  lsr_w;
  logic [2*DataW-1:0]  asr_w;
  logic [2*DataW-1:0]  rot_w;
  logic [5:0]          asr_amt;

  // Resolve the effective count and the RRX case
  always_comb begin
    cnt = req_i.imm ? {3'b000, amount_i[4:0]} : amount_i;
    rrx = req_i.rrx;
    if (req_i.imm && (amount_i[4:0] == 5'd0)) begin
      if ((req_i.kind == SK_LSR) || (req_i.kind == SK_ASR)) begin
        cnt = 8'd32;
      end
      if (req_i.kind == SK_ROR) begin
        rrx = 1'b1;
      end
    end
  end

  // Wide shifts leave the last bit shifted out next to the result
  assign big     = |cnt[7:6];
  assign lsl_w   = {{DataW{1'b0}}, value_i} << cnt[5:0];
  assign lsr_w   = {value_i, {DataW{1'b0}}} >> cnt[5:0];
  assign asr_amt = (|cnt[7:5]) ? 6'd32 : cnt[5:0];
  assign asr_w   = $unsigned($signed({value_i, {DataW{1'b0}}}) >>> asr_amt);
  assign rot_w   = {value_i, value_i} >> cnt[4:0];

  // Select result and carry; a zero count passes the value and the carry
  always_comb begin
    rsp_o.value = value_i;
    rsp_o.carry = carry_i;
    if (rrx) begin
      rsp_o.value = {carry_i, value_i[DataW-1:1]};
      rsp_o.carry = value_i[0];
    end else if (cnt != 8'd0) begin
      unique case (req_i.kind)
        SK_LSL: begin
          rsp_o.value = big ? '0 : lsl_w[DataW-1:0];
          rsp_o.carry = big ? 1'b0 : lsl_w[DataW];
        end
        SK_LSR: begin
          rsp_o.value = big ? '0 : lsr_w[2*DataW-1:DataW];
          rsp_o.carry = big ? 1'b0 : lsr_w[DataW-1];
        end
        SK_ASR: begin
          rsp_o.value = asr_w[2*DataW-1:DataW];
          rsp_o.carry = asr_w[DataW-1];
        end
        SK_ROR: begin
          rsp_o.value = rot_w[DataW-1:0];
          rsp_o.carry = rot_w[DataW-1];
        end
        default: begin
          rsp_o.value = value_i;
          rsp_o.carry = carry_i;
        end
      endcase
    end
  end

endmodule

// ----- rtl/asf_alu.sv -----
// ----------------------------------------------------------------------------
// ARM data-processing datapath
// Logic, multiply, add/subtract, compare, shifts and flag update for one item.
// ----------------------------------------------------------------------------
module asf_alu
  import asf_pkg::*;
(
  input  logic [FuncW-1:0] func_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  flags_t           flags_i,
  output logic [DataW-1:0] result_o,
  output logic             result_valid_o,
  output flags_t           flags_o
);

  logic [DataW-1:0] add_x;
  logic [DataW-1:0] add_y;
  logic             add_ci;
  logic [DataW:0]   add_sum;
  logic             add_v;
  logic [DataW-1:0] prod;
  shift_req_t       sh_req;
  shift_rsp_t       sh_rsp;
  logic [DataW-1:0] res;
  logic [DataW-1:0] fval;
  logic             vld;
  logic             set_nz;
  logic             set_cv;
  logic             set_c;

  // Pick adder operands; subtraction adds the inverted operand
  always_comb begin
    add_x  = operand_b_i;
    add_y  = operand_a_i;
    add_ci = 1'b0;
    case (func_i) inside
      FN_SUB, FN_SUBS, FN_CMP: begin
        add_y  = ~operand_a_i;
        add_ci = 1'b1;
      end
      FN_RSB, FN_RSBS: begin
        add_x  = operand_a_i;
        add_y  = ~operand_b_i;
        add_ci = 1'b1;
      end
      FN_SBC, FN_SBCS: begin
        add_y  = ~operand_a_i;
        add_ci = flags_i.c;
      end
      FN_RSC, FN_RSCS: begin
        add_x  = operand_a_i;
        add_y  = ~operand_b_i;
        add_ci = flags_i.c;
      end
      FN_ADC, FN_ADCS: begin
        add_ci = flags_i.c;
      end
      FN_NEG: begin
        add_x  = '0;
        add_y  = ~operand_a_i;
        add_ci = 1'b1;
      end
      default: begin
        add_ci = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};
  assign add_v   = (~(add_x[DataW-1] ^ add_y[DataW-1])) &
                   (add_x[DataW-1] ^ add_sum[DataW-1]);
  assign prod    = operand_a_i * operand_b_i;

  // Build the shifter request from the shift group
  always_comb begin
    sh_req.kind = SK_LSL;
    sh_req.imm  = 1'b0;
    sh_req.rrx  = 1'b0;
    case (func_i) inside
      [FN_LSL_R:FN_ROR_R]:   sh_req.kind = shift_kind_e'(2'(func_i - FN_LSL_R));
      [FN_LSL_RC:FN_ROR_RC]: sh_req.kind = shift_kind_e'(2'(func_i - FN_LSL_RC));
      [FN_LSL_RS:FN_ROR_RS]: sh_req.kind = shift_kind_e'(2'(func_i - FN_LSL_RS));
      [FN_LSL_IS:FN_ROR_IS]: begin
        sh_req.kind = shift_kind_e'(2'(func_i - FN_LSL_IS));
        sh_req.imm  = 1'b1;
      end
      FN_RRX_C, FN_RRX:      sh_req.rrx  = 1'b1;
      default:               sh_req.rrx  = 1'b0;
    endcase
  end

  asf_shifter u_shifter (
    .req_i    (sh_req),
    .value_i  (operand_a_i),
    .amount_i (operand_b_i[7:0]),
    .carry_i  (flags_i.c),
    .rsp_o    (sh_rsp)
  );

  // Decode the operation: result, flag source and which flags move
  always_comb begin
    res    = '0;
    vld    = 1'b1;
    set_nz = 1'b0;
    set_cv = 1'b0;
    set_c  = 1'b0;
    case (func_i) inside
      FN_AND, FN_ANDS:   res = operand_b_i & operand_a_i;
      FN_EOR, FN_EORS:   res = operand_b_i ^ operand_a_i;
      FN_ORR, FN_ORRS:   res = operand_b_i | operand_a_i;
      FN_BIC, FN_BICS:   res = operand_b_i & ~operand_a_i;
      FN_MUL, FN_MULS:   res = prod;
      FN_MOV, FN_MOVS:   res = operand_a_i;
      FN_MVN, FN_MVNS:   res = ~operand_a_i;
      FN_SUB, FN_RSB, FN_SBC, FN_RSC, FN_ADD, FN_ADC:
        res = add_sum[DataW-1:0];
      FN_SUBS, FN_RSBS, FN_SBCS, FN_RSCS, FN_ADDS, FN_ADCS, FN_NEG:
        res = add_sum[DataW-1:0];
      FN_TST:            res = operand_b_i & operand_a_i;
      FN_TEQ:            res = operand_b_i ^ operand_a_i;
      FN_CMP, FN_CMN:    res = add_sum[DataW-1:0];
      [FN_LSL_R:FN_RRX]: res = sh_rsp.value;
      default:           res = '0;
    endcase

    case (func_i) inside
      FN_ANDS, FN_EORS, FN_ORRS, FN_BICS, FN_MULS, FN_MOVS, FN_MVNS:
        set_nz = 1'b1;
      FN_SUBS, FN_RSBS, FN_SBCS, FN_RSCS, FN_ADDS, FN_ADCS, FN_NEG: begin
        set_nz = 1'b1;
        set_cv = 1'b1;
      end
      FN_TST, FN_TEQ: begin
        set_nz = 1'b1;
        vld    = 1'b0;
      end
      FN_CMP, FN_CMN: begin
        set_nz = 1'b1;
        set_cv = 1'b1;
        vld    = 1'b0;
      end
      [FN_LSL_RC:FN_ROR_RC], FN_RRX_C:
        set_c = 1'b1;
      [FN_LSL_RS:FN_ROR_IS]: begin
        set_nz = 1'b1;
        set_c  = 1'b1;
      end
      FN_LOADF:
        vld = 1'b0;
      [FN_AND:FN_ADC], [FN_LSL_R:FN_ROR_R], FN_RRX:
        vld = 1'b1;
      default:
        vld = 1'b0;
    endcase
  end

  assign fval = res;

  // Apply the flag updates
  always_comb begin
    flags_o = flags_i;
    if (func_i == FN_LOADF) begin
      flags_o = flags_t'(operand_a_i[DataW-1:DataW-4]);
    end
    if (set_nz) begin
      flags_o.n = fval[DataW-1];
      flags_o.z = (fval == '0);
    end
    if (set_cv) begin
      flags_o.c = add_sum[DataW];
      flags_o.v = add_v;
    end
    if (set_c) begin
      flags_o.c = sh_rsp.carry;
    end
  end

  assign result_o       = vld ? res : '0;
  assign result_valid_o = vld;

endmodule

// ----- rtl/arm_alu_shifter_flags.sv -----
// An accepted input item passes through the input register and then the result register to the master side.
// Throughput: one item per cycle while the master side takes results; the flag register feeds the next item directly.
// The input register and the result register each hold one item under backpressure.
// Reset clears both valid bits and the N, Z, C and V flags.
// ----------------------------------------------------------------------------
// ARM data-processing unit with barrel shifter and NZCV flags
// Input register, single-pass datapath, result register with flag state.
// ----------------------------------------------------------------------------
`include "arm_alu_shifter_flags_assert.svh"

module arm_alu_shifter_flags
  import asf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[5:0], operand_a[37:6], operand_b[69:38]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // result[31:0], N[32], Z[33], C[34], V[35]
  output logic        m_axis_tuser   // result_valid
);

  logic             in_valid_q;
  logic [FuncW-1:0] func_q;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic             out_valid_q;
  logic [DataW-1:0] out_result_q;
  logic             out_rv_q;
  flags_t           flags_q;
  flags_t           flags_d;
  logic [DataW-1:0] result_d;
  logic             rv_d;
  logic             advance;

  // Move an item into the result register when it is empty or being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tdata[5:0];
      a_q    <= s_axis_tdata[37:6];
      b_q    <= s_axis_tdata[69:38];
    end
  end

  asf_alu u_alu (
    .func_i         (func_q),
    .operand_a_i    (a_q),
    .operand_b_i    (b_q),
    .flags_i        (flags_q),
    .result_o       (result_d),
    .result_valid_o (rv_d),
    .flags_o        (flags_d)
  );

  // Result register and flag state advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result_d;
      out_rv_q     <= rv_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, flags_q.v, flags_q.c, flags_q.z, flags_q.n, out_result_q};
  assign m_axis_tuser  = out_rv_q;

  // Flags only move when an item completes
  `ASF_ASSERT_NEXT(a_flags_hold, !advance, $stable(flags_q))
  // An item that completes is shown next cycle
  `ASF_ASSERT_NEXT(a_adv_shows, advance, out_valid_q)
  // Flag-only operations carry a zero result
  `ASF_ASSERT_IMP(a_zero_result, out_valid_q && !out_rv_q, out_result_q == '0)
  // Load flags copies the top nibble of operand_a
  `ASF_ASSERT_NEXT(a_loadf, advance && (func_q == FN_LOADF), flags_q == $past(a_q[31:28]))

endmodule

// ----- verif/arm_alu_shifter_flags_checker.sv -----
// ----------------------------------------------------------------------------
// ARM ALU result checker
// Watches both stream channels, predicts result and NZCV flags for every
// accepted item and compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module arm_alu_shifter_flags_checker
  import asf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [71:0] s_tdata_i,   // func[5:0], operand_a[37:6], operand_b[69:38]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // result[31:0], N[32], Z[33], C[34], V[35]
  input  logic        m_tuser_i,   // result_valid
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        writes;
    flags_t      nzcv;
  } alu_out_t;

  flags_t   nzcv_state;
  alu_out_t awaited[$];
  alu_out_t want;
  int       fails = 0;

  assign fail_count_o = fails;

  function automatic void set_nz(logic [31:0] v);
    nzcv_state.n = v[31];
    nzcv_state.z = (v == 32'd0);
  endfunction

  // x + y + cin, update all four flags
  function automatic logic [31:0] add_flags(logic [31:0] x, logic [31:0] y, logic cin);
    logic [32:0] sum;
    sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
    set_nz(sum[31:0]);
    nzcv_state.c = sum[32];
    nzcv_state.v = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  // x - y - !cin, carry means no borrow
  function automatic logic [31:0] sub_flags(logic [31:0] x, logic [31:0] y, logic cin);
    logic [32:0] sum;
    sum = {1'b0, x} + {1'b0, ~y} + {32'd0, cin};
    set_nz(sum[31:0]);
    nzcv_state.c = sum[32];
    nzcv_state.v = (x[31] ^ y[31]) & (x[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  // Barrel shift with ARM register-count rules; carry passes through on count 0
  function automatic shift_rsp_t shift_value(shift_kind_e kind, logic [31:0] v,
                                             int unsigned s, logic cin);
    shift_rsp_t  rsp;
    int unsigned k;
    rsp.value = v;
    rsp.carry = cin;
    k = s % 32;
    if (s != 0) begin
      case (kind)
        SK_LSL: begin
          if (s >= 32) begin
            rsp.carry = (s == 32) ? v[0] : 1'b0;
            rsp.value = '0;
          end else begin
            rsp.carry = v[32-s];
            rsp.value = v << s;
          end
        end
        SK_LSR: begin
          if (s >= 32) begin
            rsp.carry = (s == 32) ? v[31] : 1'b0;
            rsp.value = '0;
          end else begin
            rsp.carry = v[s-1];
            rsp.value = v >> s;
          end
        end
        SK_ASR: begin
          if (s >= 32) begin
            rsp.value = {32{v[31]}};
            rsp.carry = v[31];
          end else begin
            rsp.carry = v[s-1];
            rsp.value = $signed(v) >>> s;
          end
        end
        default: begin
          if (k != 0) rsp.value = (v >> k) | (v << (32 - k));
          rsp.carry = rsp.value[31];
        end
      endcase
    end
    return rsp;
  endfunction

  // Execute one operation against the flag state and return the result item
  function automatic alu_out_t execute_op(logic [5:0] fn, logic [31:0] a, logic [31:0] b);
    alu_out_t    res;
    shift_rsp_t  sr;
    logic [31:0] r;
    logic        writes;
    logic        cin;
    int unsigned cnt;
    int unsigned imm;
    r      = '0;
    writes = 1'b1;
    cin    = nzcv_state.c;
    cnt    = 32'(b[7:0]);
    imm    = 32'(b[4:0]);
    case (fn)
      FN_AND:  r = b & a;
      FN_ANDS: begin r = b & a; set_nz(r); end
      FN_EOR:  r = b ^ a;
      FN_EORS: begin r = b ^ a; set_nz(r); end
      FN_ORR:  r = b | a;
      FN_ORRS: begin r = b | a; set_nz(r); end
      FN_BIC:  r = b & ~a;
      FN_BICS: begin r = b & ~a; set_nz(r); end
      FN_MUL:  r = a * b;
      FN_MULS: begin r = a * b; set_nz(r); end
      FN_MOV:  r = a;
      FN_MOVS: begin r = a; set_nz(r); end
      FN_MVN:  r = ~a;
      FN_MVNS: begin r = ~a; set_nz(r); end
      FN_SUB:  r = b - a;
      FN_SUBS: r = sub_flags(b, a, 1'b1);
      FN_RSB:  r = a - b;
      FN_RSBS: r = sub_flags(a, b, 1'b1);
      FN_SBC:  r = b - a - {31'd0, ~cin};
      FN_SBCS: r = sub_flags(b, a, cin);
      FN_RSC:  r = a - b - {31'd0, ~cin};
      FN_RSCS: r = sub_flags(a, b, cin);
      FN_ADD:  r = b + a;
      FN_ADDS: r = add_flags(b, a, 1'b0);
      FN_ADC:  r = b + a + {31'd0, cin};
      FN_ADCS: r = add_flags(b, a, cin);
      FN_TST:  begin set_nz(b & a); writes = 1'b0; end
      FN_TEQ:  begin set_nz(b ^ a); writes = 1'b0; end
      FN_CMP:  begin void'(sub_flags(b, a, 1'b1)); writes = 1'b0; end
      FN_CMN:  begin void'(add_flags(b, a, 1'b0)); writes = 1'b0; end
      FN_NEG:  r = sub_flags(32'd0, a, 1'b1);
      FN_LSL_R, FN_LSR_R, FN_ASR_R, FN_ROR_R: begin
        sr = shift_value(shift_kind_e'(2'(fn - FN_LSL_R)), a, cnt, cin);
        r  = sr.value;
      end
      FN_LSL_RC, FN_LSR_RC, FN_ASR_RC, FN_ROR_RC: begin
        sr = shift_value(shift_kind_e'(2'(fn - FN_LSL_RC)), a, cnt, cin);
        r  = sr.value;
        nzcv_state.c = sr.carry;
      end
      FN_LSL_RS, FN_LSR_RS, FN_ASR_RS, FN_ROR_RS: begin
        sr = shift_value(shift_kind_e'(2'(fn - FN_LSL_RS)), a, cnt, cin);
        r  = sr.value;
        nzcv_state.c = sr.carry;
        set_nz(r);
      end
      FN_LSL_IS, FN_LSR_IS, FN_ASR_IS: begin
        // immediate zero means 32 for the right shifts
        sr = shift_value(shift_kind_e'(2'(fn - FN_LSL_IS)), a,
                         (fn != FN_LSL_IS && imm == 0) ? 32 : imm, cin);
        r  = sr.value;
        nzcv_state.c = sr.carry;
        set_nz(r);
      end
      FN_ROR_IS: begin
        // immediate zero turns into rotate right through carry
        if (imm == 0) begin
          r = {cin, a[31:1]};
          nzcv_state.c = a[0];
        end else begin
          sr = shift_value(SK_ROR, a, imm, cin);
          r  = sr.value;
          nzcv_state.c = sr.carry;
        end
        set_nz(r);
      end
      FN_RRX_C: begin
        r = {cin, a[31:1]};
        nzcv_state.c = a[0];
      end
      FN_RRX:   r = {cin, a[31:1]};
      FN_LOADF: begin
        nzcv_state = a[31:28];
        writes     = 1'b0;
      end
      default:  writes = 1'b0;
    endcase
    if (!writes) r = '0;
    res.value  = r;
    res.writes = writes;
    res.nzcv   = nzcv_state;
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, actual %h", field, exp_val, act_val);
      fails++;
    end
  endfunction

  // Compare result items first, then predict for the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nzcv_state = '0;
      awaited.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited.size() == 0) begin
          $error("result item with no prediction waiting: %h", m_tdata_i);
          fails++;
        end else begin
          want = awaited.pop_front();
          check_field("result", want.value, m_tdata_i[31:0]);
          check_field("result_valid", 32'(want.writes), 32'(m_tuser_i));
          check_field("flag_negative", 32'(want.nzcv.n), 32'(m_tdata_i[32]));
          check_field("flag_zero", 32'(want.nzcv.z), 32'(m_tdata_i[33]));
          check_field("flag_carry", 32'(want.nzcv.c), 32'(m_tdata_i[34]));
          check_field("flag_overflow", 32'(want.nzcv.v), 32'(m_tdata_i[35]));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited.push_back(execute_op(s_tdata_i[5:0], s_tdata_i[37:6], s_tdata_i[69:38]));
      end
      pending_o <= awaited.size();
    end
  end

endmodule

// ----- verif/tb_arm_alu_shifter_flags.sv -----
// ----------------------------------------------------------------------------
// ARM ALU testbench
// Drives directed and random data-processing items with random gaps and
// backpressure; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_arm_alu_shifter_flags;
  import asf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // func[5:0], operand_a[37:6], operand_b[69:38]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // result[31:0], N[32], Z[33], C[34], V[35]
  logic        m_axis_tuser;   // result_valid
  int          fail_count;
  int          pending_results;

  bit tx_gaps   = 1'b0;
  bit rx_gaps   = 1'b0;
  bit rx_hold   = 1'b0;

  arm_alu_shifter_flags dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  arm_alu_shifter_flags_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Operand with a bias toward corner values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Shift count in the low byte, random upper bits
  function automatic logic [31:0] pick_count();
    logic [7:0] cnt;
    case ($urandom_range(0, 7))
      0:       cnt = 8'd0;
      1:       cnt = 8'd32;
      2:       cnt = 8'd64;
      3:       cnt = 8'($urandom_range(33, 255));
      default: cnt = 8'($urandom_range(1, 31));
    endcase
    return {24'($urandom_range(0, 32'h00FF_FFFF)), cnt};
  endfunction

  // Offer one item and hold it until accepted
  task automatic push_op(logic [5:0] fn, logic [31:0] a, logic [31:0] b);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, a, fn};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_op();
    logic [5:0] fn;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       fn = FN_LOADF;
    else if (r < 11) fn = 6'($urandom_range(FN_LOADF + 1, 63));
    else             fn = 6'($urandom_range(FN_AND, FN_RRX));
    push_op(fn, pick_word(), $urandom_range(0, 1) ? pick_count() : pick_word());
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready with runs, plus a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else if (!rx_gaps || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: flag loads, carries, overflow, shift count rules
    push_op(FN_LOADF,  32'hF000_0000, 32'h0000_0000);
    push_op(FN_ADC,    32'hFFFF_FFFF, 32'h0000_0000);
    push_op(FN_ADCS,   32'hFFFF_FFFF, 32'h0000_0000);
    push_op(FN_ADDS,   32'h0000_0001, 32'h7FFF_FFFF);
    push_op(FN_SUBS,   32'h0000_0001, 32'h8000_0000);
    push_op(FN_SBCS,   32'h0000_0005, 32'h0000_0005);
    push_op(FN_RSCS,   32'h8000_0000, 32'h7FFF_FFFF);
    push_op(FN_CMP,    32'h1234_5678, 32'h1234_5678);
    push_op(FN_CMN,    32'hFFFF_FFFF, 32'h0000_0001);
    push_op(FN_TST,    32'h0F0F_0F0F, 32'hF0F0_F0F0);
    push_op(FN_TEQ,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_op(FN_NEG,    32'h0000_0000, 32'h0000_0000);
    push_op(FN_NEG,    32'h8000_0000, 32'h0000_0000);
    push_op(FN_MULS,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(FN_ANDS,   32'hAAAA_AAAA, 32'h5555_5555);
    push_op(FN_LSL_RC, 32'h8000_0001, 32'hFFFF_FF00);
    push_op(FN_LSL_RS, 32'h0000_0001, 32'h0000_0020);
    push_op(FN_LSR_RS, 32'h8000_0000, 32'h0000_0021);
    push_op(FN_ASR_RS, 32'h8000_0000, 32'h0000_00C8);
    push_op(FN_ROR_RS, 32'h8000_0000, 32'h0000_0040);
    push_op(FN_LSL_IS, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(FN_LSR_IS, 32'h8000_0000, 32'hFFFF_FFE0);
    push_op(FN_ASR_IS, 32'h8000_0001, 32'h0000_0000);
    push_op(FN_ROR_IS, 32'h0000_0001, 32'h0000_0000);
    push_op(FN_RRX_C,  32'h0000_0003, 32'h0000_0000);
    push_op(FN_RRX,    32'h0000_0002, 32'h0000_0000);
    push_op(6'd63,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Walk every code once, unused ones too
    for (int code = 0; code < 64; code++) begin
      push_op(6'(code), pick_word(), $urandom_range(0, 1) ? pick_count() : pick_word());
    end

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (250) random_op();

    // Hold off the receiver while items keep coming, then let it drain
    rx_hold = 1'b1;
    tx_gaps = 1'b0;
    repeat (30) random_op();
    tx_gaps = 1'b1;
    wait_drained();

    repeat (300) random_op();
    wait_drained();
    repeat (6) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/asf_pkg.sv
rtl/asf_shifter.sv
rtl/asf_alu.sv
rtl/arm_alu_shifter_flags.sv
verif/arm_alu_shifter_flags_checker.sv
verif/tb_arm_alu_shifter_flags.sv
